[rtl/fifo_lock_grant_arbiter_unit_macros.svh]
// Assertion macros shared by the lock arbiter RTL.
`ifndef FIFO_LOCK_GRANT_ARBITER_UNIT_MACROS_SVH
`define FIFO_LOCK_GRANT_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication.
`define FLGA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FLGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/flga_pkg.sv]
// Package: widths, codes and shared types of the lock arbiter.
`default_nettype none

package flga_pkg;

   localparam int QueueDepthDef   = 16;
   localparam int ProcessCountDef = 256;

   localparam int OPCODE_W = 2;
   localparam int PID_W    = 8;
   localparam int CLIENT_W = 5;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 32;

   localparam logic [OPCODE_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GRANT            = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASE_UNLOCKED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN_OP       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL       = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Decision passed from the front end to the back end.
   typedef struct packed {
      logic                grant;
      logic [STATUS_W-1:0] status;
      logic [PID_W-1:0]    pid;
      logic [CLIENT_W-1:0] client;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_pull_type;

endpackage

`default_nettype wire

[rtl/flga_ifs.sv]
// Interfaces: request and response channels of the lock arbiter.
`default_nettype none

interface flga_req_if;
   import flga_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [PID_W-1:0]    process_id;
   logic [CLIENT_W-1:0] client_handle;

   modport source (output valid, output opcode, output process_id, output client_handle,
                   input ready);
   modport sink   (input valid, input opcode, input process_id, input client_handle,
                   output ready);
endinterface

interface flga_rsp_if;
   import flga_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PID_W-1:0]    grant_process_id;
   logic [CLIENT_W-1:0] grant_client;
   logic [COUNT_W-1:0]  grant_count;

   modport source (output valid, output status, output grant_process_id,
                   output grant_client, output grant_count, input ready);
   modport sink   (input valid, input status, input grant_process_id,
                   input grant_client, input grant_count, output ready);
endinterface

`default_nettype wire

[rtl/fifo_lock_grant_arbiter_unit.sv]
// A word is registered in the front end, passes the decision queue and is registered in
// the response register; a grant also passes the counter update state. The front end takes
// no new word until it has handed the last one on, and the back end takes no decision during
// a grant's read-modify-write of the grant counter RAM. Reset: synchronous, active high;
// lock free, queue empty, then all PROCESS_COUNT counters cleared while req_chan.ready stays low.
`default_nettype none

module fifo_lock_grant_arbiter_unit #(
   parameter int QUEUE_DEPTH   = flga_pkg::QueueDepthDef,
   parameter int PROCESS_COUNT = flga_pkg::ProcessCountDef
) (
   input  wire logic  clock,
   input  wire logic  reset,
   flga_req_if.sink   req_chan,
   flga_rsp_if.source rsp_chan
);
   import flga_pkg::*;

   // Front end owns lock flag, request queue pointers and the queue RAM;
   // it settles every word's outcome and hands a decision word on.
   cmd_push_type push;
   logic         push_full;

   // Back end owns the grant counters and the response register.
   cmd_pull_type pull;
   logic         pop;
   logic         clear_busy;

   flga_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clear_busy (clear_busy),
      .push       (push),
      .push_full  (push_full)
   );

   // short queue lets the front keep taking words while a response waits
   flga_cmd_queue u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (push_full),
      .pop   (pop),
      .pull  (pull)
   );

   flga_back #(
      .PROCESS_COUNT (PROCESS_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pull       (pull),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/flga_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module flga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/flga_cmd_queue.sv]
// Two-entry decision queue between front end and back end.
`default_nettype none

module flga_cmd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire flga_pkg::cmd_push_type push,
   output      logic                  full,
   input  wire logic                  pop,
   output      flga_pkg::cmd_pull_type pull
);
   import flga_pkg::*;

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   cmd_type    entries_ff [2];
   logic       do_write;
   logic       do_read;

   assign full     = (count_ff == 2'd2);
   assign do_write = push.valid & ~full;
   assign do_read  = pop & (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_write ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_read  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_write) - 2'(do_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign pull.valid = (count_ff != 2'd0);
   assign pull.cmd   = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[rtl/flga_front.sv]
// Front end: takes request words, keeps lock and queue state, decides each outcome.
`default_nettype none
`include "fifo_lock_grant_arbiter_unit_macros.svh"

module flga_front #(
   parameter int QUEUE_DEPTH = flga_pkg::QueueDepthDef
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   flga_req_if.sink                   req_chan,
   input  wire logic                  clear_busy,
   output      flga_pkg::cmd_push_type push,
   input  wire logic                  push_full
);
   import flga_pkg::*;

   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = PID_W + CLIENT_W;
   localparam logic [QIDX_W-1:0] QIDX_LAST = QIDX_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_PUSH = 1'b1;

   logic              state_ff, state_in;
   logic              lock_ff, lock_in;
   logic [QIDX_W-1:0] head_ff, head_in;
   logic [QIDX_W-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   cmd_type           cmd_ff, cmd_in;
   logic              from_queue_ff, from_queue_in;

   logic               accept;
   logic               q_wr;
   logic [ENTRY_W-1:0] q_rd_data;

   assign req_chan.ready = (state_ff == S_IDLE) & ~clear_busy;
   assign accept         = req_chan.valid & req_chan.ready;

   always_comb begin
      state_in      = state_ff;
      lock_in       = lock_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      cmd_in        = cmd_ff;
      from_queue_in = from_queue_ff;
      q_wr          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in      = S_PUSH;
               from_queue_in = 1'b0;
               cmd_in.grant  = 1'b0;
               cmd_in.status = ST_ACCEPTED;
               cmd_in.pid    = req_chan.process_id;
               cmd_in.client = req_chan.client_handle;
               unique case (req_chan.opcode)
                  OP_REQUEST: begin
                     if (fill_ff == FILL_FULL) begin
                        cmd_in.status = ST_QUEUE_FULL;
                     end else if (!lock_ff) begin
                        // free lock means empty queue: grant straight away
                        cmd_in.grant  = 1'b1;
                        cmd_in.status = ST_GRANT;
                        lock_in       = 1'b1;
                     end else begin
                        q_wr    = 1'b1;
                        tail_in = (tail_ff == QIDX_LAST) ? '0 : tail_ff + QIDX_W'(1);
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  OP_RELEASE: begin
                     if (!lock_ff) begin
                        cmd_in.status = ST_RELEASE_UNLOCKED;
                     end else if (fill_ff != '0) begin
                        // lock passes to the queue head, stays held
                        cmd_in.grant  = 1'b1;
                        cmd_in.status = ST_GRANT;
                        from_queue_in = 1'b1;
                        head_in = (head_ff == QIDX_LAST) ? '0 : head_ff + QIDX_W'(1);
                        fill_in = fill_ff - FILL_W'(1);
                     end else begin
                        lock_in = 1'b0;
                     end
                  end
                  default: begin
                     cmd_in.status = ST_UNKNOWN_OP;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (!push_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lock_ff  <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lock_ff  <= lock_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      from_queue_ff <= from_queue_in;
   end

   // head entry read on every accept; only used when the word turns out a release grant
   flga_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr),
      .wr_addr (tail_ff),
      .wr_data ({req_chan.process_id, req_chan.client_handle}),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   always_comb begin
      push.valid = (state_ff == S_PUSH);
      push.cmd   = cmd_ff;
      if (from_queue_ff) begin
         push.cmd.pid    = q_rd_data[ENTRY_W-1:CLIENT_W];
         push.cmd.client = q_rd_data[CLIENT_W-1:0];
      end
   end

   `FLGA_ASSERT_SAME(a_free_lock_empty_queue, clock, reset, !lock_ff, fill_ff == '0, "lock free with queued entries")
   `FLGA_ASSERT_SAME(a_fill_bounded, clock, reset, 1'b1, fill_ff <= FILL_FULL, "queue fill beyond depth")
   `FLGA_ASSERT_SAME(a_queue_grant_holds_lock, clock, reset, push.valid && from_queue_ff, lock_ff && push.cmd.grant, "queue grant without lock")

endmodule

`default_nettype wire

[rtl/flga_back.sv]
// Back end: clears and updates grant counters, drives the response register.
`default_nettype none
`include "fifo_lock_grant_arbiter_unit_macros.svh"

module flga_back #(
   parameter int PROCESS_COUNT = flga_pkg::ProcessCountDef
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire flga_pkg::cmd_pull_type pull,
   output      logic                   pop,
   output      logic                   clear_busy,
   flga_rsp_if.source                  rsp_chan
);
   import flga_pkg::*;

   localparam int SLOT_W    = $clog2(PROCESS_COUNT);
   localparam int PidValues = 2 ** PID_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PROCESS_COUNT - 1);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_READ  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [SLOT_W-1:0]   slot_ff;
   cmd_type             cmd_ff;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [PID_W-1:0]    out_pid_ff, out_pid_in;
   logic [CLIENT_W-1:0] out_client_ff, out_client_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic [SLOT_W-1:0]  slot_lut [PidValues];
   logic [SLOT_W-1:0]  slot;
   logic               out_free;
   logic               issue;
   logic               ram_wr_en;
   logic [SLOT_W-1:0]  ram_wr_addr;
   logic [COUNT_W-1:0] ram_wr_data;
   logic [COUNT_W-1:0] ram_rd_data;
   logic [COUNT_W-1:0] count_next;

   // process id to counter slot, folded modulo the counter count
   for (genvar g = 0; g < PidValues; g++) begin : g_slot
      assign slot_lut[g] = SLOT_W'(g % PROCESS_COUNT);
   end

   assign slot       = slot_lut[pull.cmd.pid];
   assign out_free   = ~out_valid_ff | rsp_chan.ready;
   assign issue      = (state_ff == B_IDLE) & pull.valid & out_free;
   assign pop        = issue;
   assign clear_busy = (state_ff == B_CLEAR);
   assign count_next = (ram_rd_data == COUNT_MAX) ? ram_rd_data
                                                 : ram_rd_data + COUNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      clr_ptr_in    = clr_ptr_ff;
      out_valid_in  = out_valid_ff & ~rsp_chan.ready;
      out_status_in = out_status_ff;
      out_pid_in    = out_pid_ff;
      out_client_in = out_client_ff;
      out_count_in  = out_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = count_next;
      unique case (state_ff)
         B_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ptr_ff;
            ram_wr_data = '0;
            if (clr_ptr_ff == SLOT_LAST) begin
               state_in = B_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + SLOT_W'(1);
            end
         end
         B_IDLE: begin
            if (issue) begin
               if (pull.cmd.grant) begin
                  state_in = B_READ;
               end else begin
                  out_valid_in  = 1'b1;
                  out_status_in = pull.cmd.status;
                  out_pid_in    = '0;
                  out_client_in = '0;
                  out_count_in  = '0;
               end
            end
         end
         B_READ: begin
            ram_wr_en     = 1'b1;
            out_valid_in  = 1'b1;
            out_status_in = cmd_ff.status;
            out_pid_in    = cmd_ff.pid;
            out_client_in = cmd_ff.client;
            out_count_in  = count_next;
            state_in      = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ptr_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_pid_ff    <= out_pid_in;
      out_client_ff <= out_client_in;
      out_count_ff  <= out_count_in;
      if (issue) begin
         cmd_ff  <= pull.cmd;
         slot_ff <= slot;
      end
   end

   flga_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (PROCESS_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = out_status_ff;
   assign rsp_chan.grant_process_id = out_pid_ff;
   assign rsp_chan.grant_client     = out_client_ff;
   assign rsp_chan.grant_count      = out_count_ff;

   `FLGA_ASSERT_SAME(a_read_slot_free, clock, reset, state_ff == B_READ, !out_valid_ff, "response slot busy at counter update")
   `FLGA_ASSERT_SAME(a_no_pop_in_clear, clock, reset, clear_busy, !pop, "decision taken during counter clear")
   `FLGA_ASSERT_NEXT(a_grant_goes_read, clock, reset, pop && pull.cmd.grant, state_ff == B_READ, "grant did not start counter update")

endmodule

`default_nettype wire
